@@ src/wavhdr_pkg.sv @@
// shared types and constants for the wav header chunk walker
`timescale 1ns / 1ps
`default_nettype none

package wavhdr_pkg;

  // walk phases
  typedef enum logic [2:0] {
    PH_MAGIC  = 3'd0,
    PH_FORM   = 3'd1,
    PH_HEADER = 3'd2,
    PH_FMT    = 3'd3,
    PH_SKIP   = 3'd4
  } phase_t;

  // result status codes
  localparam logic [1:0] ST_DATA  = 2'd0;
  localparam logic [1:0] ST_RAW   = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;
  localparam logic [1:0] ST_SHORT = 2'd3;

  // little-endian four character tags
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;

  // fmt body and header layout
  localparam int unsigned FMT_BODY_BYTES = 16;
  localparam int unsigned CNT_W          = 5;
  localparam logic [CNT_W-1:0] MAGIC_BYTES  = 5'd4;
  localparam logic [CNT_W-1:0] FORM_BYTES   = 5'd8;
  localparam logic [CNT_W-1:0] TAG_BYTES    = 5'd4;
  localparam logic [CNT_W-1:0] HEADER_BYTES = 5'd8;
  localparam logic [CNT_W-1:0] FMT_BYTES    = CNT_W'(FMT_BODY_BYTES);
  localparam logic [1:0] RAW_SAMPLES        = 2'd2;

  // one result request
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] channel_count;
    logic [31:0] sample_rate_hz;
    logic [15:0] sample_bits;
    logic [31:0] carried_bytes;
    logic [1:0]  carried_samples;
  } result_t;

endpackage

`default_nettype wire

@@ src/wavhdr_walker.sv @@
// per-byte header walk state machine with result decode
`timescale 1ns / 1ps
`default_nettype none

module wavhdr_walker
  import wavhdr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic [7:0]  byte_value,
  input  wire logic        end_of_stream,
  output logic             emit,
  output result_t          res
);

  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  cnt_inc;
  logic [31:0]       tag_r, tag_nxt;
  logic [31:0]       len_r, len_nxt;
  logic [31:0]       len_dec;
  logic [15:0]       chan_r, chan_nxt;
  logic [31:0]       rate_r, rate_nxt;
  logic [15:0]       bits_r, bits_nxt;
  logic              fin_r, fin_nxt;

  // state registers, updated once per accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MAGIC;
      cnt_r   <= '0;
      tag_r   <= '0;
      len_r   <= '0;
      chan_r  <= '0;
      rate_r  <= '0;
      bits_r  <= '0;
      fin_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      tag_r   <= tag_nxt;
      len_r   <= len_nxt;
      chan_r  <= chan_nxt;
      rate_r  <= rate_nxt;
      bits_r  <= bits_nxt;
      fin_r   <= fin_nxt;
    end
  end

  assign cnt_inc = cnt_r + 1'b1;
  assign len_dec = (len_r != '0) ? len_r - 32'd1 : len_r;

  // next state and result
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    tag_nxt   = tag_r;
    len_nxt   = len_r;
    chan_nxt  = chan_r;
    rate_nxt  = rate_r;
    bits_nxt  = bits_r;
    fin_nxt   = fin_r;
    emit      = 1'b0;
    res       = '0;

    if (end_of_stream) begin
      // stream end rearms everything
      if (!fin_r) begin
        emit       = 1'b1;
        res.status = ST_TRUNC;
      end
      phase_nxt = PH_MAGIC;
      cnt_nxt   = '0;
      tag_nxt   = '0;
      len_nxt   = '0;
      chan_nxt  = '0;
      rate_nxt  = '0;
      bits_nxt  = '0;
      fin_nxt   = 1'b0;
    end else if (!fin_r) begin
      unique case (phase_r)
        PH_MAGIC: begin
          tag_nxt = {byte_value, tag_r[31:8]};
          cnt_nxt = cnt_inc;
          if (cnt_inc >= MAGIC_BYTES) begin
            if (tag_nxt == TAG_RIFF) begin
              phase_nxt = PH_FORM;
              cnt_nxt   = '0;
            end else begin
              emit                = 1'b1;
              fin_nxt             = 1'b1;
              res.status          = ST_RAW;
              res.carried_bytes   = tag_nxt;
              res.carried_samples = RAW_SAMPLES;
            end
          end
        end
        PH_FORM: begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= FORM_BYTES) begin
            phase_nxt = PH_HEADER;
            cnt_nxt   = '0;
          end
        end
        PH_HEADER: begin
          if (cnt_r < TAG_BYTES) begin
            tag_nxt = {byte_value, tag_r[31:8]};
          end else begin
            len_nxt = {byte_value, len_r[31:8]};
          end
          cnt_nxt = cnt_inc;
          if (cnt_inc >= HEADER_BYTES) begin
            cnt_nxt = '0;
            if (tag_nxt == TAG_DATA) begin
              emit               = 1'b1;
              fin_nxt            = 1'b1;
              res.status         = ST_DATA;
              res.channel_count  = chan_r;
              res.sample_rate_hz = rate_r;
              res.sample_bits    = bits_r;
            end else if (tag_nxt == TAG_FMT) begin
              if (len_nxt < 32'(FMT_BODY_BYTES)) begin
                emit       = 1'b1;
                fin_nxt    = 1'b1;
                res.status = ST_SHORT;
              end else begin
                phase_nxt = PH_FMT;
              end
            end else if (len_nxt != '0) begin
              phase_nxt = PH_SKIP;
            end
          end
        end
        PH_FMT: begin
          // pick the fields out of the fmt body by offset
          unique case (cnt_r)
            5'd2:    chan_nxt[7:0]   = byte_value;
            5'd3:    chan_nxt[15:8]  = byte_value;
            5'd4:    rate_nxt[7:0]   = byte_value;
            5'd5:    rate_nxt[15:8]  = byte_value;
            5'd6:    rate_nxt[23:16] = byte_value;
            5'd7:    rate_nxt[31:24] = byte_value;
            5'd14:   bits_nxt[7:0]   = byte_value;
            5'd15:   bits_nxt[15:8]  = byte_value;
            default: ;
          endcase
          cnt_nxt = cnt_inc;
          if (cnt_inc >= FMT_BYTES) begin
            cnt_nxt = '0;
            if (len_r > 32'(FMT_BODY_BYTES)) begin
              len_nxt   = len_r - 32'(FMT_BODY_BYTES);
              phase_nxt = PH_SKIP;
            end else begin
              phase_nxt = PH_HEADER;
            end
          end
        end
        PH_SKIP: begin
          len_nxt = len_dec;
          if (len_dec == '0) begin
            phase_nxt = PH_HEADER;
            cnt_nxt   = '0;
          end
        end
        default: begin
          phase_nxt = PH_HEADER;
          cnt_nxt   = '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/wav_header_chunk_walker_core.sv @@
// top level: input handshake, header walker and registered result channel
//
//  channel | ports                                    | dir | accepted when
//  --------+------------------------------------------+-----+-----------------------
//  input   | in_byte_value, in_end_of_stream          | in  | in_valid & in_ready
//  result  | out_status .. out_carried_samples        | out | out_valid & out_ready
//
// one byte per cycle while in_ready is high; its result, if any, shows the next cycle
// the work per byte is one compare, shift and count between state and result register
// reset clears the walk to the magic check and empties the result register
// in_ready drops only while a result waits and out_ready is low
`timescale 1ns / 1ps
`default_nettype none

module wav_header_chunk_walker_core
  import wavhdr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic        in_end_of_stream,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [15:0]      out_channel_count,
  output logic [31:0]      out_sample_rate_hz,
  output logic [15:0]      out_sample_bits,
  output logic [31:0]      out_carried_bytes,
  output logic [1:0]       out_carried_samples
);

  logic    in_acc;
  logic    emit;
  result_t res;
  result_t res_r;
  logic    out_valid_r, out_valid_nxt;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  // header walk
  wavhdr_walker u_walker (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (in_acc),
    .byte_value    (in_byte_value),
    .end_of_stream (in_end_of_stream),
    .emit          (emit),
    .res           (res)
  );

  // result register
  assign out_valid_nxt = (out_valid_r && !out_ready) || (in_acc && emit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = res_r.status;
  assign out_channel_count   = res_r.channel_count;
  assign out_sample_rate_hz  = res_r.sample_rate_hz;
  assign out_sample_bits     = res_r.sample_bits;
  assign out_carried_bytes   = res_r.carried_bytes;
  assign out_carried_samples = res_r.carried_samples;

  // checks
  a_raw_samples: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_status == ST_RAW) == (out_carried_samples == RAW_SAMPLES)))
    else $error("carried sample count does not match raw status");

  a_fmt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_DATA) |->
      (out_channel_count == '0 && out_sample_rate_hz == '0 && out_sample_bits == '0))
    else $error("fmt fields set on a non-data result");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && emit) |=> out_valid)
    else $error("result request lost");

endmodule

`default_nettype wire

@@ bench/wav_header_chunk_walker_core_tb.sv @@
// self-checking testbench for the wav header chunk walker core
`timescale 1ns / 1ps

import wavhdr_pkg::*;

// expected-result store plus a byte-level model of the chunk walk
class header_verdict_board;
  result_t     verdict_q[$];
  int unsigned failures;
  phase_t      walk_phase;
  int unsigned step_count;
  logic [31:0] tag_window;
  logic [31:0] chunk_left;
  logic [15:0] chans_hold;
  logic [31:0] rate_hold;
  logic [15:0] bits_hold;
  bit          verdict_given;

  function new();
    failures = 0;
    rearm();
  endfunction

  // end of stream returns the walk to its reset state
  function void rearm();
    walk_phase    = PH_MAGIC;
    step_count    = 0;
    tag_window    = '0;
    chunk_left    = '0;
    chans_hold    = '0;
    rate_hold     = '0;
    bits_hold     = '0;
    verdict_given = 1'b0;
  endfunction

  function void open_header();
    walk_phase = PH_HEADER;
    step_count = 0;
  endfunction

  function void post_verdict(logic [1:0] status, bit with_fmt, bit raw);
    result_t r;
    r.status          = status;
    r.channel_count   = with_fmt ? chans_hold : 16'd0;
    r.sample_rate_hz  = with_fmt ? rate_hold : 32'd0;
    r.sample_bits     = with_fmt ? bits_hold : 16'd0;
    r.carried_bytes   = raw ? tag_window : 32'd0;
    r.carried_samples = raw ? RAW_SAMPLES : 2'd0;
    verdict_q.push_back(r);
    verdict_given = 1'b1;
  endfunction

  // advance the walk by one accepted request
  function void note_request(logic [7:0] b, logic eos);
    if (eos) begin
      if (!verdict_given) post_verdict(ST_TRUNC, 1'b0, 1'b0);
      rearm();
      return;
    end
    if (verdict_given) return;
    case (walk_phase)
      PH_MAGIC: begin
        tag_window = {b, tag_window[31:8]};
        step_count++;
        if (step_count >= 4) begin
          if (tag_window == TAG_RIFF) begin
            walk_phase = PH_FORM;
            step_count = 0;
          end else begin
            post_verdict(ST_RAW, 1'b0, 1'b1);
          end
        end
      end
      PH_FORM: begin
        step_count++;
        if (step_count >= 8) open_header();
      end
      PH_HEADER: begin
        if (step_count < 4) tag_window = {b, tag_window[31:8]};
        else chunk_left = {b, chunk_left[31:8]};
        step_count++;
        if (step_count >= 8) begin
          step_count = 0;
          if (tag_window == TAG_DATA) begin
            post_verdict(ST_DATA, 1'b1, 1'b0);
          end else if (tag_window == TAG_FMT) begin
            if (chunk_left < FMT_BODY_BYTES) post_verdict(ST_SHORT, 1'b0, 1'b0);
            else walk_phase = PH_FMT;
          end else if (chunk_left != 0) begin
            walk_phase = PH_SKIP;
          end
        end
      end
      PH_FMT: begin
        // byte offsets inside the fmt body
        case (step_count)
          2:  chans_hold[7:0]  = b;
          3:  chans_hold[15:8] = b;
          4:  rate_hold[7:0]   = b;
          5:  rate_hold[15:8]  = b;
          6:  rate_hold[23:16] = b;
          7:  rate_hold[31:24] = b;
          14: bits_hold[7:0]   = b;
          15: bits_hold[15:8]  = b;
          default: ;
        endcase
        step_count++;
        if (step_count >= FMT_BODY_BYTES) begin
          if (chunk_left > FMT_BODY_BYTES) begin
            chunk_left = chunk_left - FMT_BODY_BYTES;
            walk_phase = PH_SKIP;
            step_count = 0;
          end else begin
            open_header();
          end
        end
      end
      PH_SKIP: begin
        if (chunk_left != 0) chunk_left--;
        if (chunk_left == 0) open_header();
      end
      default: open_header();
    endcase
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
      failures++;
    end
  endfunction

  // match an accepted result against the oldest expectation
  function void check_result(result_t seen);
    result_t want;
    if (verdict_q.size() == 0) begin
      $display("%0t unexpected result: expected none actual %h", $time, seen);
      failures++;
      return;
    end
    want = verdict_q.pop_front();
    compare_field("status", 32'(want.status), 32'(seen.status));
    compare_field("channel_count", 32'(want.channel_count), 32'(seen.channel_count));
    compare_field("sample_rate_hz", want.sample_rate_hz, seen.sample_rate_hz);
    compare_field("sample_bits", 32'(want.sample_bits), 32'(seen.sample_bits));
    compare_field("carried_bytes", want.carried_bytes, seen.carried_bytes);
    compare_field("carried_samples", 32'(want.carried_samples),
                  32'(seen.carried_samples));
  endfunction

  function int unsigned pending();
    return verdict_q.size();
  endfunction
endclass

module wav_header_chunk_walker_core_tb;

  localparam int unsigned ITEM_TARGET = 2000;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte_value;
  logic        in_end_of_stream;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [15:0] out_channel_count;
  logic [31:0] out_sample_rate_hz;
  logic [15:0] out_sample_bits;
  logic [31:0] out_carried_bytes;
  logic [1:0]  out_carried_samples;

  header_verdict_board board;
  logic [7:0]          stream_bytes[$];
  bit                  no_idle = 1'b0;
  int unsigned         sent_bytes = 0;
  int unsigned         cycle_count = 0;

  wav_header_chunk_walker_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_byte_value       (in_byte_value),
    .in_end_of_stream    (in_end_of_stream),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_channel_count   (out_channel_count),
    .out_sample_rate_hz  (out_sample_rate_hz),
    .out_sample_bits     (out_sample_bits),
    .out_carried_bytes   (out_carried_bytes),
    .out_carried_samples (out_carried_samples)
  );

  // clock
  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result acceptance and checking
  always @(posedge clk) begin : result_monitor
    result_t seen;
    seen = {out_status, out_channel_count, out_sample_rate_hz, out_sample_bits,
            out_carried_bytes, out_carried_samples};
    if (rst_n && out_valid && out_ready) board.check_result(seen);
  end

  // receiver stalls, one draw per result
  initial begin : result_sink
    int unsigned stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_valid && out_ready));
    end
  end

  // one byte request, with a random gap before it
  task automatic send_request(input logic [7:0] b, input logic eos);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_byte_value    <= b;
    in_end_of_stream <= eos;
    do @(posedge clk); while (!in_ready);
    board.note_request(b, eos);
  endtask

  // send the built stream, then end of stream
  task automatic send_stream();
    foreach (stream_bytes[i]) send_request(stream_bytes[i], 1'b0);
    send_request(8'($urandom_range(0, 255)), 1'b1);
    sent_bytes += stream_bytes.size();
    stream_bytes.delete();
  endtask

  // hold off the sender until every expected result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  task automatic put_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) stream_bytes.push_back(v[8*i +: 8]);
  endtask

  task automatic put_random(input int n);
    for (int i = 0; i < n; i++) stream_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // fmt chunk header and body, excess bytes random
  task automatic put_fmt(input logic [31:0] len, input logic [15:0] chans,
                         input logic [31:0] rate, input logic [15:0] bits);
    put_le(TAG_FMT, 4);
    put_le(len, 4);
    put_random(2);
    put_le(32'(chans), 2);
    put_le(rate, 4);
    put_random(6);
    put_le(32'(bits), 2);
    put_random(len - FMT_BODY_BYTES);
  endtask

  // unknown chunk of a small size
  task automatic put_other_chunk();
    logic [31:0] tag;
    int unsigned len;
    tag = $urandom;
    if (tag == TAG_DATA || tag == TAG_FMT) tag ^= 32'h1;
    len = $urandom_range(0, 12);
    put_le(tag, 4);
    put_le(len, 4);
    put_random(len);
  endtask

  // riff preamble, a few chunks, then the data header
  task automatic build_wav();
    int unsigned chunks;
    put_le(TAG_RIFF, 4);
    put_random(8);
    chunks = $urandom_range(0, 3);
    repeat (chunks) begin
      if ($urandom_range(0, 1) == 1)
        put_fmt(16 + $urandom_range(0, 6), 16'($urandom), $urandom, 16'($urandom));
      else
        put_other_chunk();
    end
    put_le(TAG_DATA, 4);
    put_le($urandom, 4);
  endtask

  initial begin : stimulus
    int unsigned kind;
    int unsigned cut;
    int unsigned stream_no;
    board            = new();
    stream_no        = 0;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_byte_value    <= 8'h00;
    in_end_of_stream <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty stream reports truncation
    send_stream();
    // raw pcm, trailing bytes ignored
    put_le(32'h7F80_FF00, 4);
    put_random(2);
    send_stream();
    // data right after the preamble, no fmt seen
    put_le(TAG_RIFF, 4);
    put_random(8);
    put_le(TAG_DATA, 4);
    put_le(32'h0, 4);
    send_stream();
    // zero-size and odd-size chunks, extreme fmt, then a second fmt that wins
    put_le(TAG_RIFF, 4);
    put_le(32'hFFFF_FFFF, 4);
    put_le(32'h0, 4);
    put_le(32'h5453_494C, 4);
    put_le(32'h0, 4);
    put_le(32'h6B6E_756A, 4);
    put_le(32'h3, 4);
    put_random(3);
    put_fmt(16, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_stream();
    put_le(TAG_RIFF, 4);
    put_random(8);
    put_fmt(16, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    put_fmt(18, 16'h0001, 32'h0000_0000, 16'h0008);
    put_le(TAG_DATA, 4);
    put_le(32'hFFFF_FFFF, 4);
    put_random(2);
    send_stream();
    // fmt chunk one byte too short
    put_le(TAG_RIFF, 4);
    put_random(8);
    put_le(TAG_FMT, 4);
    put_le(32'd15, 4);
    send_stream();
    // stream ends inside the fmt body
    put_le(TAG_RIFF, 4);
    put_random(8);
    put_le(TAG_FMT, 4);
    put_le(32'd16, 4);
    put_random(5);
    send_stream();
    wait_drained();

    // random streams, mostly well-formed
    while (sent_bytes < ITEM_TARGET) begin
      kind    = $urandom_range(0, 99);
      no_idle = ($urandom_range(0, 4) == 0);
      if (kind < 55) begin
        build_wav();
        put_random($urandom_range(0, 3));
      end else if (kind < 65) begin
        put_le(TAG_RIFF, 4);
        put_random(8);
        if ($urandom_range(0, 1) == 1) put_other_chunk();
        put_le(TAG_FMT, 4);
        put_le($urandom_range(0, 15), 4);
        put_random($urandom_range(0, 3));
      end else if (kind < 75) begin
        put_random(4 + $urandom_range(0, 3));
      end else if (kind < 88) begin
        build_wav();
        cut = $urandom_range(0, stream_bytes.size() - 1);
        while (stream_bytes.size() > cut) void'(stream_bytes.pop_back());
      end else begin
        put_random($urandom_range(0, 12));
      end
      send_stream();
      if (stream_no % 8 == 7) wait_drained();
      stream_no++;
    end

    // drain and settle
    no_idle = 1'b0;
    wait_drained();
    repeat (4) @(posedge clk);
    if (board.failures == 0 && board.pending() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
